FILE: rtl/priority_message_queue_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef PRIORITY_MESSAGE_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_MESSAGE_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define PMQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define PMQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared constants, types and state codes of the priority message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pmq_pkg;

    localparam int SLOTS     = 16;
    localparam int MSG_BYTES = 64;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int BYTE_W = $clog2(MSG_BYTES);
    localparam int CNT_W  = $clog2(MSG_BYTES + 1);
    localparam int ADDR_W = IDX_W + BYTE_W;
    localparam int PRIO_W = 15;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

    localparam logic [7:0] CFG_MESSAGE_SIZE = 8'd0;
    localparam logic [7:0] CFG_QUEUE_DEPTH  = 8'd1;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_PRIO  = 3'd1,
        STATUS_TOO_LONG  = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_EMPTY     = 3'd4,
        STATUS_BUF_SHORT = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_WALK,
        ST_FIX,
        ST_EMIT,
        ST_RX_POP,
        ST_RX_RD,
        ST_RX_OUT
    } state_t;

    // Write requests into the link table.
    typedef struct packed {
        logic              nl_we;
        logic [IDX_W-1:0]  nl_idx;
        logic [PTR_W-1:0]  nl_data;
        logic              sl_we;
        logic [IDX_W-1:0]  sl_idx;
        logic [PRIO_W-1:0] sl_prio;
        logic [CNT_W-1:0]  sl_len;
        logic              init;
    } lt_wr_t;

endpackage

`default_nettype wire

FILE: rtl/pmq_payload_ram.sv
// ----------------------------------------------------------------------------
// pmq_payload_ram
// Payload byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pmq_payload_ram (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [pmq_pkg::ADDR_W-1:0] waddr,
    input  wire logic [7:0]                wdata,
    input  wire logic                      re,
    input  wire logic [pmq_pkg::ADDR_W-1:0] raddr,
    output logic      [7:0]                rdata
);
    import pmq_pkg::*;

    logic [7:0] mem [SLOTS*MSG_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pmq_link_table.sv
// ----------------------------------------------------------------------------
// pmq_link_table
// Slot links, priorities and lengths, with the shared priority comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module pmq_link_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pmq_pkg::lt_wr_t           wr,
    input  wire logic [pmq_pkg::PTR_W-1:0] depth,
    input  wire logic [pmq_pkg::IDX_W-1:0] rd_idx,
    input  wire logic [pmq_pkg::PRIO_W-1:0] key,
    output logic      [pmq_pkg::PTR_W-1:0] rd_next,
    output logic      [pmq_pkg::PRIO_W-1:0] rd_prio,
    output logic      [pmq_pkg::CNT_W-1:0] rd_len,
    output logic                           rd_ge
);
    import pmq_pkg::*;

    logic [PTR_W-1:0]  next_reg  [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic [PRIO_W-1:0] prio_reg  [SLOTS];
    logic [CNT_W-1:0]  len_reg   [SLOTS];
    logic [PTR_W:0]    succ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.init)
        begin
            valid_reg <= '0;
        end
        else if (wr.nl_we)
        begin
            valid_reg[wr.nl_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.nl_we)
        begin
            next_reg[wr.nl_idx] <= wr.nl_data;
        end
        if (wr.sl_we)
        begin
            prio_reg[wr.sl_idx] <= wr.sl_prio;
            len_reg[wr.sl_idx]  <= wr.sl_len;
        end
    end

    // An unwritten link reads as the free chain laid down at init.
    always_comb
    begin
        succ = (PTR_W+1)'(rd_idx) + 1'b1;
        if (valid_reg[rd_idx])
        begin
            rd_next = next_reg[rd_idx];
        end
        else if (succ < {1'b0, depth})
        begin
            rd_next = succ[PTR_W-1:0];
        end
        else
        begin
            rd_next = NIL;
        end
        rd_prio = prio_reg[rd_idx];
        rd_len  = len_reg[rd_idx];
        rd_ge   = (prio_reg[rd_idx] >= key);
    end

endmodule

`default_nettype wire

FILE: rtl/priority_message_queue_unit.sv
// ----------------------------------------------------------------------------
// priority_message_queue_unit
// Fixed-slot message queue ordered by priority, FIFO within a priority.
// ----------------------------------------------------------------------------
// A send byte that does not end its message is taken and gives no result.
// The item ending a send pops a free slot and records its header, then links
// the message in by walking the list one slot per cycle through a single
// comparator, links it behind its predecessor or as the new head, and emits
// the result. An error result is emitted without the walk. A receive unlinks
// the head and then reads and emits each payload byte in turn, through the
// registered read of the payload store. The input is not ready while an item
// is being worked on; configuration writes are always ready, and size or depth writes empty the queue.
`default_nettype none

module priority_message_queue_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tdata: priority_req[15:0], data_byte[23:16], has_byte[24],
    //        buffer_length[40:25], zero fill [47:41]
    input  wire logic [47:0] s_tdata,
    // tuser: func
    input  wire logic        s_tuser,
    // tlast: last_of_message
    input  wire logic        s_tlast,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: data_byte_out[7:0], byte_valid[8], priority_out[23:9],
    //        length_out[30:24], readable[31], writable[32],
    //        message_count[37:33], zero fill [39:38]
    output logic      [39:0] m_tdata,
    // tuser: status
    output logic      [2:0]  m_tuser,
    // tlast: last
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import pmq_pkg::*;

    state_t            state_reg,  state_next;
    logic [6:0]        msize_cfg_reg, msize_cfg_next;
    logic [4:0]        depth_cfg_reg, depth_cfg_next;
    logic [PTR_W-1:0]  head_reg,   head_next;
    logic [PTR_W-1:0]  free_reg,   free_next;
    logic [PTR_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              disc_reg,   disc_next;
    logic [IDX_W-1:0]  slot_reg,   slot_next;
    logic [PTR_W-1:0]  cur_reg,    cur_next;
    logic [PTR_W-1:0]  prev_reg,   prev_next;
    logic [PRIO_W-1:0] key_reg,    key_next;
    logic [CNT_W-1:0]  len_reg,    len_next;
    status_t           status_reg, status_next;
    logic [PRIO_W-1:0] rx_prio_reg, rx_prio_next;
    logic [CNT_W-1:0]  idx_reg,    idx_next;

    logic              ovalid_reg, ovalid_next;
    logic [37:0]       odata_reg,  odata_next;
    logic [2:0]        ostat_reg,  ostat_next;
    logic              olast_reg,  olast_next;

    logic [CNT_W-1:0]  msize;
    logic [PTR_W-1:0]  depth;
    logic              out_free;
    logic              acc;
    logic [15:0]       in_prio;
    logic [7:0]        in_byte;
    logic              in_has;
    logic [15:0]       in_buflen;
    logic [CNT_W-1:0]  cnt_upd;
    logic              disc_upd;
    logic              writable;

    lt_wr_t            lt_wr;
    logic [IDX_W-1:0]  lt_rd_idx;
    logic [PTR_W-1:0]  lt_next;
    logic [PRIO_W-1:0] lt_prio;
    logic [CNT_W-1:0]  lt_len;
    logic              lt_ge;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    pmq_link_table u_link (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (lt_wr),
        .depth   (depth),
        .rd_idx  (lt_rd_idx),
        .key     (key_reg),
        .rd_next (lt_next),
        .rd_prio (lt_prio),
        .rd_len  (lt_len),
        .rd_ge   (lt_ge)
    );

    pmq_payload_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign msize     = (msize_cfg_reg > 7'(MSG_BYTES)) ? CNT_W'(MSG_BYTES)
                                                       : CNT_W'(msize_cfg_reg);
    assign depth     = (depth_cfg_reg > 5'(SLOTS)) ? PTR_W'(SLOTS) : PTR_W'(depth_cfg_reg);
    assign out_free  = !ovalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign acc       = s_tvalid && s_tready;
    assign in_prio   = s_tdata[15:0];
    assign in_byte   = s_tdata[23:16];
    assign in_has    = s_tdata[24];
    assign in_buflen = s_tdata[40:25];
    assign writable  = (count_reg < depth);

    assign m_tdata  = {2'b00, odata_reg};
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;
    assign m_tvalid = ovalid_reg;

    always_comb
    begin
        state_next     = state_reg;
        msize_cfg_next = msize_cfg_reg;
        depth_cfg_next = depth_cfg_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        disc_next      = disc_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        status_next    = status_reg;
        rx_prio_next   = rx_prio_reg;
        idx_next       = idx_reg;
        ovalid_next    = ovalid_reg && !m_tready;
        odata_next     = odata_reg;
        ostat_next     = ostat_reg;
        olast_next     = olast_reg;
        lt_wr          = '0;
        lt_rd_idx      = slot_reg;
        ram_we         = 1'b0;
        ram_waddr      = {free_reg[IDX_W-1:0], cnt_reg[BYTE_W-1:0]};
        ram_re         = 1'b0;
        ram_raddr      = {slot_reg, idx_reg[BYTE_W-1:0]};
        cnt_upd        = cnt_reg;
        disc_upd       = disc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && !s_tuser)
                begin
                    if (in_has)
                    begin
                        if (cnt_reg < msize)
                        begin
                            ram_we  = (free_reg < NIL);
                            cnt_upd = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            disc_upd = 1'b1;
                        end
                    end
                    cnt_next  = cnt_upd;
                    disc_next = disc_upd;
                    if (s_tlast)
                    begin
                        cnt_next     = '0;
                        disc_next    = 1'b0;
                        rx_prio_next = '0;
                        len_next     = cnt_upd;
                        key_next     = in_prio[PRIO_W-1:0];
                        slot_next    = free_reg[IDX_W-1:0];
                        state_next   = ST_EMIT;
                        if (in_prio[15])
                        begin
                            status_next = STATUS_BAD_PRIO;
                        end
                        else if (disc_upd)
                        begin
                            status_next = STATUS_TOO_LONG;
                        end
                        else if (free_reg >= NIL || !writable)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            state_next = ST_ALLOC;
                        end
                    end
                end
                else if (acc)
                begin
                    cnt_next     = '0;
                    disc_next    = 1'b0;
                    rx_prio_next = '0;
                    slot_next    = head_reg[IDX_W-1:0];
                    state_next   = ST_EMIT;
                    if (in_buflen < 16'(msize))
                    begin
                        status_next = STATUS_BUF_SHORT;
                    end
                    else if (count_reg == '0 || head_reg >= NIL)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_RX_POP;
                    end
                end
            end
            ST_ALLOC:
            begin
                // pop the free list and record the message header
                free_next     = lt_next;
                lt_wr.sl_we   = 1'b1;
                lt_wr.sl_idx  = slot_reg;
                lt_wr.sl_prio = key_reg;
                lt_wr.sl_len  = len_reg;
                cur_next      = head_reg;
                prev_next     = NIL;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                lt_rd_idx = cur_reg[IDX_W-1:0];
                if (cur_reg < NIL && lt_ge)
                begin
                    prev_next = cur_reg;
                    cur_next  = lt_next;
                end
                else
                begin
                    lt_wr.nl_we   = 1'b1;
                    lt_wr.nl_idx  = slot_reg;
                    lt_wr.nl_data = cur_reg;
                    state_next    = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (prev_reg < NIL)
                begin
                    lt_wr.nl_we   = 1'b1;
                    lt_wr.nl_idx  = prev_reg[IDX_W-1:0];
                    lt_wr.nl_data = PTR_W'(slot_reg);
                end
                else
                begin
                    head_next = PTR_W'(slot_reg);
                end
                count_next  = count_reg + 1'b1;
                status_next = STATUS_OK;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = status_reg;
                    olast_next  = 1'b1;
                    odata_next  = {count_reg, writable, (count_reg != '0), 7'd0,
                                   rx_prio_reg, 1'b0, 8'd0};
                    state_next  = ST_IDLE;
                end
            end
            ST_RX_POP:
            begin
                // unlink the head and return its slot to the free list
                head_next     = lt_next;
                lt_wr.nl_we   = 1'b1;
                lt_wr.nl_idx  = slot_reg;
                lt_wr.nl_data = free_reg;
                free_next     = PTR_W'(slot_reg);
                count_next    = count_reg - 1'b1;
                rx_prio_next  = lt_prio;
                len_next      = lt_len;
                idx_next      = '0;
                status_next   = STATUS_OK;
                state_next    = (lt_len == '0) ? ST_EMIT : ST_RX_RD;
            end
            ST_RX_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_RX_OUT;
            end
            ST_RX_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = STATUS_OK;
                    olast_next  = (idx_reg + 1'b1 == len_reg);
                    odata_next  = {count_reg, writable, (count_reg != '0), len_reg[6:0],
                                   rx_prio_reg, 1'b1, ram_rdata};
                    idx_next    = idx_reg + 1'b1;
                    state_next  = (idx_reg + 1'b1 == len_reg) ? ST_IDLE : ST_RX_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write empties the queue
        if (cfg_valid && (cfg_index == CFG_MESSAGE_SIZE || cfg_index == CFG_QUEUE_DEPTH))
        begin
            if (cfg_index == CFG_MESSAGE_SIZE)
            begin
                msize_cfg_next = cfg_data[6:0];
            end
            else
            begin
                depth_cfg_next = cfg_data[4:0];
            end
            lt_wr.init = 1'b1;
            head_next  = NIL;
            free_next  = (cfg_index == CFG_QUEUE_DEPTH)
                         ? ((cfg_data[4:0] != '0) ? '0 : NIL)
                         : ((depth != '0) ? '0 : NIL);
            count_next = '0;
            cnt_next   = '0;
            disc_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            msize_cfg_reg <= 7'(MSG_BYTES);
            depth_cfg_reg <= 5'(SLOTS);
            head_reg      <= NIL;
            free_reg      <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            disc_reg      <= 1'b0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            msize_cfg_reg <= msize_cfg_next;
            depth_cfg_reg <= depth_cfg_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            disc_reg      <= disc_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        key_reg     <= key_next;
        len_reg     <= len_next;
        status_reg  <= status_next;
        rx_prio_reg <= rx_prio_next;
        idx_reg     <= idx_next;
        odata_reg   <= odata_next;
        ostat_reg   <= ostat_next;
        olast_reg   <= olast_next;
    end

endmodule

`default_nettype wire

FILE: rtl/pmq_checker.sv
// ----------------------------------------------------------------------------
// pmq_checker
// Port-level checks on the result stream of the priority message queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_message_queue_unit_assert.svh"

module pmq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic [39:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    import pmq_pkg::*;

    `PMQ_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat dropped while stalled")
    `PMQ_ASSERT_NOW(a_err_single, m_tvalid && m_tuser != STATUS_OK, m_tlast && !m_tdata[8], "error result not a single beat")
    `PMQ_ASSERT_NOW(a_readable, m_tvalid, m_tdata[31] == (m_tdata[37:33] != 5'd0), "readable disagrees with count")
    `PMQ_ASSERT_NOW(a_status, m_tvalid, m_tuser <= STATUS_BUF_SHORT, "status code out of range")

endmodule

bind priority_message_queue_unit pmq_checker u_pmq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
